### rtl/scsd_pkg.sv
// Shared types and constants for the self-calibrating stick decoder
`timescale 1ns / 1ps
`default_nettype none

package scsd_pkg;

	// field widths
	localparam int AXIS_BITS  = 15;
	localparam int PORT_BITS  = 2;
	localparam int COUNT_BITS = 3;
	localparam int DIR_BITS   = 10;

	// register reset and calibration limits
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);
	localparam logic [AXIS_BITS-1:0]  MIN_SPAN    = AXIS_BITS'(100);
	localparam logic [AXIS_BITS-1:0]  AXIS_MAX    = {AXIS_BITS{1'b1}};

	// divide by three as multiply by an under-estimated reciprocal
	localparam int DIV3_SHIFT   = AXIS_BITS + 1;
	localparam int DIV3_MUL_INT = (1 << DIV3_SHIFT) / 3;
	localparam logic [AXIS_BITS-1:0] DIV3_MUL = AXIS_BITS'(DIV3_MUL_INT);

	// bit positions in the direction word
	localparam int DIR_DOWN  = 0;
	localparam int DIR_RIGHT = 1;
	localparam int DIR_UP    = 8;
	localparam int DIR_LEFT  = 9;

	// one stick sample request
	typedef struct packed {
		logic [PORT_BITS-1:0] port_number;
		logic                 sample_valid;
		logic [AXIS_BITS-1:0] stick_x;
		logic [AXIS_BITS-1:0] stick_y;
		logic                 button_raw;
	} smp_t;

	// one direction result
	typedef struct packed {
		logic [DIR_BITS-1:0] direction_word;
		logic                fire;
	} dir_t;

	// one axis after calibration update
	typedef struct packed {
		logic [AXIS_BITS-1:0] value;
		logic [AXIS_BITS-1:0] lo;
		logic [AXIS_BITS-1:0] span;
	} axis_t;

	// calibrated sample handed to the classification stage
	typedef struct packed {
		axis_t x;
		axis_t y;
		logic  active;
		logic  button_raw;
	} cal_t;

endpackage

`default_nettype wire

### rtl/scsd_calib.sv
// Running min/max calibration state and stick count register
`timescale 1ns / 1ps
`default_nettype none

module scsd_calib (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [scsd_pkg::COUNT_BITS-1:0]   cfg_data,
	input  wire logic                              take,
	input  wire scsd_pkg::smp_t                    smp,
	output scsd_pkg::cal_t                         cal
);

	logic [scsd_pkg::COUNT_BITS-1:0] count_q;
	logic [scsd_pkg::AXIS_BITS-1:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [scsd_pkg::AXIS_BITS-1:0]  x_lo_n, x_hi_n, y_lo_n, y_hi_n;
	logic [scsd_pkg::AXIS_BITS-1:0]  x_span, y_span;
	logic                            port_ok;
	logic                            upd;

	// port attached and sample usable
	assign port_ok = {1'b0, smp.port_number} < count_q;
	assign upd     = take & port_ok & smp.sample_valid;

	// widen the ranges to take in this sample
	always_comb begin
		x_hi_n = (smp.stick_x > x_hi_q) ? smp.stick_x : x_hi_q;
		x_lo_n = (smp.stick_x < x_lo_q) ? smp.stick_x : x_lo_q;
		y_hi_n = (smp.stick_y > y_hi_q) ? smp.stick_y : y_hi_q;
		y_lo_n = (smp.stick_y < y_lo_q) ? smp.stick_y : y_lo_q;
		x_span = x_hi_n - x_lo_n;
		y_span = y_hi_n - y_lo_n;
	end

	// calibrated sample for the next stage
	always_comb begin
		cal.x.value    = smp.stick_x;
		cal.x.lo       = x_lo_n;
		cal.x.span     = x_span;
		cal.y.value    = smp.stick_y;
		cal.y.lo       = y_lo_n;
		cal.y.span     = y_span;
		cal.active     = port_ok & smp.sample_valid
			& (x_span >= scsd_pkg::MIN_SPAN) & (y_span >= scsd_pkg::MIN_SPAN);
		cal.button_raw = smp.button_raw;
	end

	// stick count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= scsd_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	// min/max state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q <= scsd_pkg::AXIS_MAX;
			x_hi_q <= '0;
			y_lo_q <= scsd_pkg::AXIS_MAX;
			y_hi_q <= '0;
		end else if (upd) begin
			x_lo_q <= x_lo_n;
			x_hi_q <= x_hi_n;
			y_lo_q <= y_lo_n;
			y_hi_q <= y_hi_n;
		end
	end

endmodule

`default_nettype wire

### rtl/scsd_third.sv
// Splits one axis into thirds of its calibrated span
`timescale 1ns / 1ps
`default_nettype none

module scsd_third (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire scsd_pkg::axis_t axis,
	output logic               low,
	output logic               high
);

	localparam int A = scsd_pkg::AXIS_BITS;

	logic [2*A-1:0] prod;
	logic [A-1:0]   q_est;
	logic [A-1:0]   val_s3, lo_s3, span_s3, q_s3;
	logic [A+1:0]   q3, r_est, r_fix;
	logic           fix;
	logic [A-1:0]   q;
	logic [A:0]     lower;
	logic [A+1:0]   upper;

	// estimate span/3, may fall short by one
	assign prod  = {{A{1'b0}}, axis.span} * {{A{1'b0}}, scsd_pkg::DIV3_MUL};
	assign q_est = {1'b0, prod[2*A-1:scsd_pkg::DIV3_SHIFT]};

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			val_s3  <= axis.value;
			lo_s3   <= axis.lo;
			span_s3 <= axis.span;
			q_s3    <= q_est;
		end
	end

	// correct quotient and remainder
	always_comb begin
		q3    = {2'b00, q_s3} + {1'b0, q_s3, 1'b0};
		r_est = {2'b00, span_s3} - q3;
		fix   = r_est >= (A+2)'(3);
		q     = q_s3 + A'(fix);
		r_fix = fix ? r_est - (A+2)'(3) : r_est;
	end

	// edges at lo + span/3 and lo + 2*span/3
	always_comb begin
		lower = {1'b0, lo_s3} + {1'b0, q};
		upper = {2'b00, lo_s3} + {1'b0, q, 1'b0} + (A+2)'(r_fix >= (A+2)'(2));
		low   = {1'b0, val_s3} < lower;
		high  = {2'b00, val_s3} > upper;
	end

endmodule

`default_nettype wire

### rtl/self_calibrating_stick_to_directions.sv
// Top level: analog stick samples in, calibrated direction words out
//
// Usage:
//   smp carries one stick sample per request (smp_valid / smp_ready).
//   dir returns exactly one direction word and fire bit per sample
//   (dir_valid / dir_ready), in request order.
//   cfg writes the stick count register (cfg_valid / cfg_ready); it is
//   always ready; users write it only while idle, the block does not enforce it.
// Timing:
//   A sample passes the input, calibrated sample, stage-three and
//   result registers. One sample per cycle while dir_ready is high;
//   the only loop is the calibration min/max compare and select.
// Reset:
//   arst_n clears the stage valid flags, sets the stick count to one and
//   sets the ranges to empty (minimum all ones, maximum zero).
// Stall:
//   When dir_ready is low the pipeline keeps filling its empty stages,
//   then holds; smp_ready drops only once all four stages are full.
`timescale 1ns / 1ps
`default_nettype none

module self_calibrating_stick_to_directions (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            smp_valid,
	output logic                                 smp_ready,
	input  wire scsd_pkg::smp_t                  smp,
	output logic                                 dir_valid,
	input  wire logic                            dir_ready,
	output scsd_pkg::dir_t                       dir,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [scsd_pkg::COUNT_BITS-1:0] cfg_data
);

	logic           v_s1, v_s2, v_s3, v_s4;
	logic           en1, en2, en3, en4;
	scsd_pkg::smp_t smp_s1;
	scsd_pkg::cal_t cal;
	scsd_pkg::cal_t cal_s2;
	logic           active_s3, btn_s3;
	logic           x_low, x_high, y_low, y_high;
	scsd_pkg::dir_t dir_n;
	scsd_pkg::dir_t dir_s4;

	// stage enables, each stage moves when the next can take it
	assign en4       = !v_s4 || dir_ready;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign smp_ready = en1;
	assign cfg_ready = 1'b1;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= smp_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && smp_valid) begin
			smp_s1 <= smp;
		end
	end

	// calibration update as the sample leaves stage one
	scsd_calib u_calib (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.take     (v_s1 & en2),
		.smp      (smp_s1),
		.cal      (cal)
	);

	// calibrated sample register
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			cal_s2 <= cal;
		end
	end

	// thirds per axis, each holds its own stage-three register
	scsd_third u_third_x (
		.clk  (clk),
		.en   (en3 & v_s2),
		.axis (cal_s2.x),
		.low  (x_low),
		.high (x_high)
	);

	scsd_third u_third_y (
		.clk  (clk),
		.en   (en3 & v_s2),
		.axis (cal_s2.y),
		.low  (y_low),
		.high (y_high)
	);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			active_s3 <= cal_s2.active;
			btn_s3    <= cal_s2.button_raw;
		end
	end

	// quadrature direction word and fire from the active-low button
	always_comb begin
		dir_n = '0;
		if (active_s3) begin
			dir_n.direction_word[scsd_pkg::DIR_RIGHT] = x_low;
			dir_n.direction_word[scsd_pkg::DIR_LEFT]  = x_high;
			dir_n.direction_word[scsd_pkg::DIR_DOWN]  = y_low ^ x_low;
			dir_n.direction_word[scsd_pkg::DIR_UP]    = y_high ^ x_high;
			dir_n.fire                                = ~btn_s3;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			dir_s4 <= dir_n;
		end
	end

	assign dir_valid = v_s4;
	assign dir       = dir_s4;

`ifndef SYNTHESIS
	// input stalls only when the whole pipeline backs up behind the output
	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_ready |-> (dir_valid && !dir_ready))
		else $error("input stalled without a full pipeline");

	// right and left never both set
	a_no_both_x: assert property (@(posedge clk) disable iff (!arst_n)
		dir_valid |-> !(dir.direction_word[scsd_pkg::DIR_RIGHT]
			&& dir.direction_word[scsd_pkg::DIR_LEFT]))
		else $error("right and left both set");

	// unused direction bits stay clear
	a_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		dir_valid |-> (dir.direction_word[7:2] == 6'd0))
		else $error("unused direction bits set");
`endif

endmodule

`default_nettype wire
